// ----- src/hkvt_pkg.sv -----
// hkvt_pkg: types and constants shared by the hashed key-value table
// holds the item structs, command codes and sequencer states
// no dependencies
package hkvt_pkg;

    // fixed field widths of the item channels
    localparam int KEY_BITS  = 32;
    localparam int DATA_BITS = 32;
    localparam int CFG_BITS  = 6;

    // bucket count after reset
    localparam logic [CFG_BITS-1:0] BUCKET_COUNT_RESET = 6'd19;

    // command codes
    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    // input item
    typedef struct packed {
        logic [1:0]           command;
        logic [KEY_BITS-1:0]  key;
        logic [DATA_BITS-1:0] value;
        logic [DATA_BITS-1:0] miss_value;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [DATA_BITS-1:0] result_value;
        logic                 found;
        logic                 bucket_full;
    } out_item_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } state_t;

endpackage

// ----- src/hashed_key_value_table.sv -----
// hashed_key_value_table: bucketed key-value store with identity hash
// depends on hkvt_pkg for item structs, command codes and states
//
// usage
//   s_valid/s_ready/s_item take one item (command, key, value, default).
//   m_valid/m_ready/m_item give exactly one result item per input item.
//   cfg_valid/cfg_ready/cfg_bucket_count write the bucket count; write it
//   only while no item is in flight. cfg_ready is always high.
// timing
//   the bucket is key mod bucket count, found by a shared restoring
//   subtract unit one key bit a cycle; the bucket's slots are then read
//   one a cycle from the key and value memories, compared in the cycle
//   after each read. An item goes through the divide, walk, drain and
//   finish steps before its result is registered and the next item is
//   accepted. One item is worked on at a time.
// reset
//   aresetn (synchronous, active low) clears all slot valid bits at once,
//   sets the bucket count to 19 and drops any pending result.
// stalls
//   a result waits in the output register while m_ready is low, and the
//   next item is still accepted; that item then holds in its last step
//   until the output register frees.
module hashed_key_value_table
    import hkvt_pkg::*;
#(
    parameter int MAX_BUCKETS      = 32,
    parameter int SLOTS_PER_BUCKET = 8,
    parameter int VALUE_BITS       = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  in_item_t            s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output out_item_t           m_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_BITS-1:0] cfg_bucket_count
);

    localparam int TOTAL_SLOTS = MAX_BUCKETS * SLOTS_PER_BUCKET;
    localparam int ADDR_W      = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
    localparam int NB_W        = $clog2(MAX_BUCKETS + 1);
    localparam int CNT_W       = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int DIV_CNT_W   = $clog2(KEY_BITS);

    // control registers
    state_t                  state_reg, state_next;
    logic [CFG_BITS-1:0]     bucket_count_reg;
    logic                    m_valid_reg, m_valid_next;
    logic                    cmp_pend_reg, cmp_pend_next;
    logic                    hit_reg, hit_next;
    logic                    free_found_reg, free_found_next;
    logic [DIV_CNT_W-1:0]    div_cnt_reg, div_cnt_next;
    logic [CNT_W-1:0]        slot_cnt_reg, slot_cnt_next;
    logic [TOTAL_SLOTS-1:0]  valid_reg;

    // payload registers
    logic [1:0]              cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]     key_reg, key_next;
    logic [VALUE_BITS-1:0]   val_reg, val_next;
    logic [DATA_BITS-1:0]    dflt_reg, dflt_next;
    logic [KEY_BITS-1:0]     dvd_reg, dvd_next;
    logic [NB_W-1:0]         div_reg, div_next;
    logic [NB_W-1:0]         rem_reg, rem_next;
    logic [ADDR_W-1:0]       cmp_addr_reg, cmp_addr_next;
    logic [ADDR_W-1:0]       hit_addr_reg, hit_addr_next;
    logic [ADDR_W-1:0]       free_addr_reg, free_addr_next;
    logic [VALUE_BITS-1:0]   hit_val_reg, hit_val_next;
    out_item_t               out_reg, out_next;

    // slot memories, read data registered
    logic [KEY_BITS-1:0]     key_mem [TOTAL_SLOTS];
    logic [VALUE_BITS-1:0]   val_mem [TOTAL_SLOTS];
    logic [KEY_BITS-1:0]     key_rd_reg;
    logic [VALUE_BITS-1:0]   val_rd_reg;

    // combinational helpers
    logic [NB_W-1:0]             n_eff;
    logic [NB_W:0]               trial;
    logic [ADDR_W-1:0]           walk_addr;
    logic                        rd_en;
    logic                        wr_en;
    logic                        valid_set;
    logic                        valid_clr;
    logic [ADDR_W-1:0]           wr_addr;
    logic                        out_free;
    logic                        slot_match;
    logic [VALUE_BITS+31:0]      in_ext;
    logic [VALUE_BITS+31:0]      hit_ext;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_item    = out_reg;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    // effective bucket count: zero reads as one, large counts saturate
    always_comb begin
        if (bucket_count_reg == '0) begin
            n_eff = NB_W'(1);
        end else if (int'(bucket_count_reg) > MAX_BUCKETS) begin
            n_eff = NB_W'(MAX_BUCKETS);
        end else begin
            n_eff = NB_W'(bucket_count_reg);
        end
    end

    // shared subtract unit of the restoring modulo
    assign trial = {rem_reg, dvd_reg[KEY_BITS-1]};

    // slot address under walk
    assign walk_addr = ADDR_W'(32'(rem_reg) * 32'(SLOTS_PER_BUCKET) + 32'(slot_cnt_reg));

    // value width adaptation
    assign in_ext  = {{VALUE_BITS{1'b0}}, s_item.value};
    assign hit_ext = {32'd0, hit_val_reg};

    // compare of the slot read in the previous cycle
    assign slot_match = valid_reg[cmp_addr_reg] && (key_rd_reg == key_reg);

    // sequencer: next state, datapath steps and table updates
    always_comb begin
        state_next      = state_reg;
        m_valid_next    = m_valid_reg;
        cmp_pend_next   = 1'b0;
        hit_next        = hit_reg;
        free_found_next = free_found_reg;
        div_cnt_next    = div_cnt_reg;
        slot_cnt_next   = slot_cnt_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        dflt_next       = dflt_reg;
        dvd_next        = dvd_reg;
        div_next        = div_reg;
        rem_next        = rem_reg;
        cmp_addr_next   = cmp_addr_reg;
        hit_addr_next   = hit_addr_reg;
        free_addr_next  = free_addr_reg;
        hit_val_next    = hit_val_reg;
        out_next        = out_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        valid_set       = 1'b0;
        valid_clr       = 1'b0;
        wr_addr         = hit_addr_reg;

        // output register empties when taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // slot compare, first match and first free slot win
        if (cmp_pend_reg) begin
            if (slot_match && !hit_reg) begin
                hit_next      = 1'b1;
                hit_addr_next = cmp_addr_reg;
                hit_val_next  = val_rd_reg;
            end
            if (!valid_reg[cmp_addr_reg] && !free_found_reg) begin
                free_found_next = 1'b1;
                free_addr_next  = cmp_addr_reg;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next        = s_item.command;
                    key_next        = s_item.key;
                    val_next        = in_ext[VALUE_BITS-1:0];
                    dflt_next       = s_item.miss_value;
                    dvd_next        = s_item.key;
                    div_next        = n_eff;
                    rem_next        = '0;
                    div_cnt_next    = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (trial >= {1'b0, div_reg}) begin
                    rem_next = NB_W'(trial - {1'b0, div_reg});
                end else begin
                    rem_next = trial[NB_W-1:0];
                end
                dvd_next     = {dvd_reg[KEY_BITS-2:0], 1'b0};
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(KEY_BITS - 1)) begin
                    slot_cnt_next = '0;
                    state_next    = ST_WALK;
                end
            end
            ST_WALK: begin
                rd_en         = 1'b1;
                cmp_pend_next = 1'b1;
                cmp_addr_next = walk_addr;
                slot_cnt_next = slot_cnt_reg + CNT_W'(1);
                if (slot_cnt_reg == CNT_W'(SLOTS_PER_BUCKET - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    out_next.result_value = '0;
                    out_next.found        = hit_reg;
                    out_next.bucket_full  = 1'b0;
                    case (cmd_reg)
                        CMD_LOOKUP: begin
                            out_next.result_value = hit_reg ? hit_ext[31:0] : dflt_reg;
                        end
                        CMD_INSERT: begin
                            if (hit_reg) begin
                                wr_en   = 1'b1;
                                wr_addr = hit_addr_reg;
                            end else if (free_found_reg) begin
                                wr_en     = 1'b1;
                                valid_set = 1'b1;
                                wr_addr   = free_addr_reg;
                            end else begin
                                out_next.bucket_full = 1'b1;
                            end
                        end
                        CMD_REMOVE: begin
                            valid_clr = hit_reg;
                        end
                        default: begin
                            out_next.found = 1'b0;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            bucket_count_reg <= BUCKET_COUNT_RESET;
            m_valid_reg      <= 1'b0;
            cmp_pend_reg     <= 1'b0;
            hit_reg          <= 1'b0;
            free_found_reg   <= 1'b0;
            div_cnt_reg      <= '0;
            slot_cnt_reg     <= '0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            cmp_pend_reg   <= cmp_pend_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            div_cnt_reg    <= div_cnt_next;
            slot_cnt_reg   <= slot_cnt_next;
            if (cfg_valid) begin
                bucket_count_reg <= cfg_bucket_count;
            end
        end
    end

    // slot valid bits, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (valid_set) begin
            valid_reg[wr_addr] <= 1'b1;
        end else if (valid_clr) begin
            valid_reg[wr_addr] <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        val_reg       <= val_next;
        dflt_reg      <= dflt_next;
        dvd_reg       <= dvd_next;
        div_reg       <= div_next;
        rem_reg       <= rem_next;
        cmp_addr_reg  <= cmp_addr_next;
        hit_addr_reg  <= hit_addr_next;
        free_addr_reg <= free_addr_next;
        hit_val_reg   <= hit_val_next;
        out_reg       <= out_next;
    end

    // key and value memories: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr] <= key_reg;
            val_mem[wr_addr] <= val_reg;
        end
        if (rd_en) begin
            key_rd_reg <= key_mem[walk_addr];
            val_rd_reg <= val_mem[walk_addr];
        end
    end

`ifndef ASSERT_OFF
    // partial remainder stays below the divisor during the modulo
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVIDE) |-> (rem_reg < div_reg))
        else $error("modulo remainder out of range");

    // a new result only comes out of the final step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the final step");

    // a dropped insert never reports a present key
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(out_reg.found && out_reg.bucket_full))
        else $error("found and bucket_full both set");

    // the walk never runs past the end of a bucket
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (32'(slot_cnt_reg) < SLOTS_PER_BUCKET))
        else $error("slot walk past bucket end");
`endif

endmodule
